[rtl/key_event_autorepeat_top_macros.svh]
// Assertion macros used by the key tracker RTL.
`ifndef KEY_EVENT_AUTOREPEAT_TOP_MACROS_SVH
`define KEY_EVENT_AUTOREPEAT_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define KEA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key tracker assertion failed");

// Next-cycle implication, checked outside reset.
`define KEA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key tracker assertion failed");

`else

`define KEA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KEA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/kea_pkg.sv]
package kea_pkg;

  // Number of tracked buttons; mapped bits at or above it are dropped.
  localparam int NUM_BUTTONS = 12;

  // Fixed field widths.
  localparam int KEY_CODE_W = 10;
  localparam int KEY_VAL_W  = 2;
  localparam int TIME_W     = 32;
  localparam int DELAY_W    = 8;
  localparam int BTN_OUT_W  = 12;
  localparam int CFG_IDX_W  = 1;

  // Item kinds carried in the op field.
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // Key values.
  localparam logic [KEY_VAL_W-1:0] KEY_RELEASE    = 2'd0;
  localparam logic [KEY_VAL_W-1:0] KEY_AUTOREPEAT = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 1'd1;
  localparam logic [DELAY_W-1:0]   FIRST_DELAY_RST   = 8'd30;
  localparam logic [DELAY_W-1:0]   REPEAT_PERIOD_RST = 8'd8;

  // Button bit positions.
  localparam int BTN_UP     = 0;
  localparam int BTN_DOWN   = 1;
  localparam int BTN_LEFT   = 2;
  localparam int BTN_RIGHT  = 3;
  localparam int BTN_A      = 4;
  localparam int BTN_B      = 5;
  localparam int BTN_X      = 6;
  localparam int BTN_Y      = 7;
  localparam int BTN_L      = 8;
  localparam int BTN_R      = 9;
  localparam int BTN_START  = 10;
  localparam int BTN_SELECT = 11;

  typedef logic [NUM_BUTTONS-1:0] btn_mask_t;

  // Linux key code to button mask; unmapped codes give an empty mask.
  function automatic btn_mask_t map_key(input logic [KEY_CODE_W-1:0] code);
    logic [31:0] wide;
    wide = '0;
    case (code)
      10'd29, 10'd97:  wide[BTN_A]      = 1'b1;
      10'd56, 10'd100: wide[BTN_B]      = 1'b1;
      10'd57:          wide[BTN_X]      = 1'b1;
      10'd42, 10'd54:  wide[BTN_Y]      = 1'b1;
      10'd15:          wide[BTN_L]      = 1'b1;
      10'd14:          wide[BTN_R]      = 1'b1;
      10'd28, 10'd96:  wide[BTN_START]  = 1'b1;
      10'd1:           wide[BTN_SELECT] = 1'b1;
      10'd103:         wide[BTN_UP]     = 1'b1;
      10'd108:         wide[BTN_DOWN]   = 1'b1;
      10'd105:         wide[BTN_LEFT]   = 1'b1;
      10'd106:         wide[BTN_RIGHT]  = 1'b1;
      default:         wide = '0;
    endcase
    return wide[NUM_BUTTONS-1:0];
  endfunction

endpackage

[rtl/kea_if.sv]
// Input channel: key events and polls.
interface kea_in_if import kea_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic                  is_key_event;
  logic [KEY_CODE_W-1:0] key_code;
  logic [KEY_VAL_W-1:0]  key_value;
  logic [TIME_W-1:0]     now_time;
  logic                  repeat_mode;

  modport source (output valid, op, is_key_event, key_code, key_value, now_time,
                  repeat_mode, input ready);
  modport sink (input valid, op, is_key_event, key_code, key_value, now_time,
                repeat_mode, output ready);
endinterface

// Result channel: one beat per poll.
interface kea_out_if import kea_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BTN_OUT_W-1:0] buttons;
  logic                 was_repeat_mode;

  modport source (output valid, buttons, was_repeat_mode, input ready);
  modport sink (input valid, buttons, was_repeat_mode, output ready);
endinterface

[rtl/key_event_autorepeat_top.sv]
// Key event tracker with typematic autorepeat. One beat is accepted per clock
// cycle when the result side keeps up; a beat passes an input register and, if it
// is a poll, goes on from there into the result register when that has room. Key events
// update the held mask and give no result. A repeat-mode poll compares and re-arms
// all button deadlines at once through one 32-bit add and compare lane per button,
// which sets the single-cycle rate. The deadlines are flip-flops cleared by reset,
// so no clearing pass is needed. Configuration writes take effect at once.
`include "key_event_autorepeat_top_macros.svh"

module key_event_autorepeat_top import kea_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  kea_in_if.sink               in_ch,
  kea_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]   cfg_data
);

  // Configuration registers.
  logic [DELAY_W-1:0] first_delay_r;
  logic [DELAY_W-1:0] repeat_period_r;

  // Input stage.
  logic                  s1_valid_r;
  logic                  s1_op_r;
  logic                  s1_is_key_r;
  logic [KEY_CODE_W-1:0] s1_code_r;
  logic [KEY_VAL_W-1:0]  s1_val_r;
  logic [TIME_W-1:0]     s1_now_r;
  logic                  s1_rep_r;

  // Tracker state.
  btn_mask_t         held_r, held_nxt;
  logic [TIME_W-1:0] deadline_r   [NUM_BUTTONS];
  logic [TIME_W-1:0] deadline_nxt [NUM_BUTTONS];
  btn_mask_t         fire;
  btn_mask_t         dl_busy;

  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  logic [BTN_OUT_W-1:0] out_buttons_r, out_buttons_nxt;
  logic                 out_rep_r, out_rep_nxt;

  logic s1_is_poll;
  logic s1_adv;
  logic rep_adv;

  // The input stage moves on unless a poll is blocked by a full result register.
  assign s1_is_poll  = (s1_op_r == OP_POLL);
  assign s1_adv      = s1_valid_r && (!s1_is_poll || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign rep_adv     = s1_adv && s1_is_poll && s1_rep_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r   <= FIRST_DELAY_RST;
      repeat_period_r <= REPEAT_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_DELAY:   first_delay_r   <= cfg_data;
        CFG_REPEAT_PERIOD: repeat_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r     <= in_ch.op;
      s1_is_key_r <= in_ch.is_key_event;
      s1_code_r   <= in_ch.key_code;
      s1_val_r    <= in_ch.key_value;
      s1_now_r    <= in_ch.now_time;
      s1_rep_r    <= in_ch.repeat_mode;
    end
  end

  // Held mask update from key events; autorepeat and non-key events are ignored.
  always_comb begin
    btn_mask_t bit_m;
    bit_m    = map_key(s1_code_r);
    held_nxt = held_r;
    if (s1_adv && !s1_is_poll && s1_is_key_r && (s1_val_r != KEY_AUTOREPEAT)) begin
      if (s1_val_r != KEY_RELEASE) begin
        held_nxt = held_r | bit_m;
      end else begin
        held_nxt = held_r & ~bit_m;
      end
    end
  end

  // One deadline lane per button: fire on first press or once the deadline passed.
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      logic              idle;
      logic [DELAY_W-1:0] addend;
      idle            = (deadline_r[i] == '0);
      addend          = idle ? first_delay_r : repeat_period_r;
      dl_busy[i]      = !idle;
      fire[i]         = 1'b0;
      deadline_nxt[i] = deadline_r[i];
      if (held_r[i]) begin
        if (idle || (deadline_r[i] < s1_now_r)) begin
          fire[i]         = 1'b1;
          deadline_nxt[i] = s1_now_r + TIME_W'(addend);
        end
      end else begin
        deadline_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        deadline_r[i] <= '0;
      end
    end else begin
      held_r <= held_nxt;
      if (rep_adv) begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          deadline_r[i] <= deadline_nxt[i];
        end
      end
    end
  end

  // Result register: loaded by a poll, emptied when the beat is taken.
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_buttons_nxt = out_buttons_r;
    out_rep_nxt     = out_rep_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv && s1_is_poll) begin
      out_valid_nxt   = 1'b1;
      out_buttons_nxt = s1_rep_r ? BTN_OUT_W'(fire) : BTN_OUT_W'(held_r);
      out_rep_nxt     = s1_rep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_buttons_r <= out_buttons_nxt;
    out_rep_r     <= out_rep_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.buttons         = out_buttons_r;
  assign out_ch.was_repeat_mode = out_rep_r;

  // Checks on the stage control and the deadline lanes.
  `KEA_ASSERT_IMP(a_stall_cause, clk, rst_n, !in_ch.ready, s1_valid_r && out_valid_r)
  `KEA_ASSERT_NXT(a_rep_result, clk, rst_n, rep_adv, out_valid_r && out_rep_r)
  `KEA_ASSERT_NXT(a_fire_held, clk, rst_n, rep_adv,
                  (out_buttons_r & ~BTN_OUT_W'($past(held_r))) == '0)
  `KEA_ASSERT_NXT(a_released_idle, clk, rst_n, rep_adv,
                  (dl_busy & ~$past(held_r)) == '0)

endmodule
